>>> rtl/lfu_pr_pkg.sv
package lfu_pr_pkg;

   localparam int PAGE_IN_W   = 7;
   localparam int PAGE_IN_N   = 1 << PAGE_IN_W;
   localparam int FRAME_OUT_W = 4;
   localparam int CSR_W       = 5;
   localparam int FAULT_W     = 16;

   localparam logic [CSR_W-1:0]   FRAMES_RESET = 5'd16;
   localparam logic [FAULT_W-1:0] FAULT_MAX    = '1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK
   } lfu_state_type;

endpackage

>>> rtl/lfu_pr_victim_sel.sv
module lfu_pr_victim_sel #(
   parameter int NUM_FRAMES  = 16,
   parameter int COUNT_WIDTH = 16,
   parameter int FIDX_W      = 4
) (
   input  logic                   clock,
   input  logic [NUM_FRAMES-1:0]  active,
   input  logic [NUM_FRAMES-1:0]  valid,
   input  logic [COUNT_WIDTH-1:0] freq [NUM_FRAMES],
   output logic                   empty_found,
   output logic [FIDX_W-1:0]      empty_idx,
   output logic [FIDX_W-1:0]      min_idx
);

   localparam int LEAF_N = 1 << $clog2(NUM_FRAMES);
   localparam int NODE_N = 2 * LEAF_N - 1;

   logic                   nd_ok   [NODE_N];
   logic [COUNT_WIDTH-1:0] nd_freq [NODE_N];
   logic [FIDX_W-1:0]      nd_idx  [NODE_N];

   logic                   empty_found_ff;
   logic [FIDX_W-1:0]      empty_idx_ff;
   logic [FIDX_W-1:0]      min_idx_ff;
   logic                   empty_found_in;
   logic [FIDX_W-1:0]      empty_idx_in;

   for (genvar l = 0; l < LEAF_N; l++) begin : g_leaf
      if (l < NUM_FRAMES) begin : g_real
         assign nd_ok[LEAF_N-1+l]   = active[l];
         assign nd_freq[LEAF_N-1+l] = freq[l];
         assign nd_idx[LEAF_N-1+l]  = FIDX_W'(l);
      end else begin : g_pad
         assign nd_ok[LEAF_N-1+l]   = 1'b0;
         assign nd_freq[LEAF_N-1+l] = '0;
         assign nd_idx[LEAF_N-1+l]  = '0;
      end
   end

   // left subtree holds the lower indices, so ties stay left
   for (genvar i = 0; i < LEAF_N - 1; i++) begin : g_node
      logic pick_r;
      assign pick_r = nd_ok[2*i+2] &&
                      (!nd_ok[2*i+1] || (nd_freq[2*i+2] < nd_freq[2*i+1]));
      assign nd_ok[i]   = nd_ok[2*i+1] || nd_ok[2*i+2];
      assign nd_freq[i] = pick_r ? nd_freq[2*i+2] : nd_freq[2*i+1];
      assign nd_idx[i]  = pick_r ? nd_idx[2*i+2] : nd_idx[2*i+1];
   end

   always_comb begin
      empty_found_in = 1'b0;
      empty_idx_in   = '0;
      for (int j = NUM_FRAMES - 1; j >= 0; j--) begin
         if (active[j] && !valid[j]) begin
            empty_found_in = 1'b1;
            empty_idx_in   = FIDX_W'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      min_idx_ff     <= nd_idx[0];
   end

   assign empty_found = empty_found_ff;
   assign empty_idx   = empty_idx_ff;
   assign min_idx     = min_idx_ff;

endmodule

>>> rtl/lfu_page_replacement_top.sv
// LFU page replacement unit.
// Input: raise start with req_page_number while busy is low; the item is taken
// at that clock edge. Each item gives exactly one result, shown on the rsp_
// ports for one cycle with rsp_valid high; the receiver cannot stall it.
// Configuration: csr_we with csr_wdata writes frames_in_use (0 acts as 1,
// values above NUM_FRAMES act as NUM_FRAMES). Write only while idle; busy
// stays high for one cycle after a write.
// Timing: the result is registered at the edge after acceptance and shown for
// one cycle. Items do not overlap, because of the read-modify-write of the
// per-page reference counter in its registered-read memory: read issued at
// acceptance, update and frame decision in the following cycle, next item
// taken at the edge that ends the result cycle.
// Victim choice (first empty active frame, else least frequency, lowest index
// on ties) comes from a selector registered every cycle over the frame
// registers.
// Reset: synchronous, active high. Afterwards a clearing pass zeroes the
// counter memory, one entry per cycle, with busy high; all frames start empty
// and the fault total at zero.
module lfu_page_replacement_top import lfu_pr_pkg::*; #(
   parameter int NUM_FRAMES  = 16,
   parameter int NUM_PAGES   = 128,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [PAGE_IN_W-1:0]   req_page_number,
   input  logic                   csr_we,
   input  logic [CSR_W-1:0]       csr_wdata,
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic [FRAME_OUT_W-1:0] rsp_frame_slot,
   output logic                   rsp_evicted_valid,
   output logic [PAGE_IN_W-1:0]   rsp_evicted_page,
   output logic [FAULT_W-1:0]     rsp_fault_total
);

   localparam int PAGE_W = $clog2(NUM_PAGES);
   localparam int FIDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int NF_W   = $clog2(NUM_FRAMES + 1);
   localparam int NW     = (CSR_W > NF_W) ? CSR_W : NF_W;

   lfu_state_type state_ff, state_in;

   logic [PAGE_W-1:0]      page_map [PAGE_IN_N];
   logic [COUNT_WIDTH-1:0] cnt_mem  [NUM_PAGES];
   logic [COUNT_WIDTH-1:0] cnt_rd_ff;
   logic [PAGE_W-1:0]      clr_addr_ff, clr_addr_in;
   logic [PAGE_W-1:0]      page_ff;
   logic [CSR_W-1:0]       csr_frames_ff;
   logic                   settle_ff;
   logic [FAULT_W-1:0]     fault_ff;

   logic [PAGE_W-1:0]      fpage_ff  [NUM_FRAMES];
   logic [COUNT_WIDTH-1:0] ffreq_ff  [NUM_FRAMES];
   logic [NUM_FRAMES-1:0]  fvalid_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [FIDX_W-1:0]      rsp_sel_ff;
   logic                   rsp_ev_valid_ff;
   logic [PAGE_W-1:0]      rsp_ev_page_ff;

   logic                   accept;
   logic                   look;
   logic                   mem_we;
   logic [PAGE_W-1:0]      mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;
   logic [COUNT_WIDTH-1:0] cnt_new;
   logic [NW-1:0]          n_act;
   logic [NUM_FRAMES-1:0]  act;
   logic                   hit;
   logic [FIDX_W-1:0]      hit_idx;
   logic                   empty_found;
   logic [FIDX_W-1:0]      empty_idx;
   logic [FIDX_W-1:0]      min_idx;
   logic [FIDX_W-1:0]      sel;

   for (genvar g = 0; g < PAGE_IN_N; g++) begin : g_map
      assign page_map[g] = PAGE_W'(g % NUM_PAGES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      accept      = 1'b0;
      look        = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = page_ff;
      mem_wdata   = cnt_new;
      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + PAGE_W'(1);
            if (clr_addr_ff == PAGE_W'(NUM_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start && !settle_ff) begin
               accept   = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            look     = 1'b1;
            mem_we   = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE) || settle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cnt_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         cnt_rd_ff <= cnt_mem[page_map[req_page_number]];
         page_ff   <= page_map[req_page_number];
      end
   end

   assign cnt_new = (cnt_rd_ff == '1) ? cnt_rd_ff : cnt_rd_ff + COUNT_WIDTH'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_frames_ff <= FRAMES_RESET;
         settle_ff     <= 1'b0;
      end else begin
         settle_ff <= csr_we;
         if (csr_we) begin
            csr_frames_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      if (csr_frames_ff == '0) begin
         n_act = NW'(1);
      end else if (NW'(csr_frames_ff) > NW'(NUM_FRAMES)) begin
         n_act = NW'(NUM_FRAMES);
      end else begin
         n_act = NW'(csr_frames_ff);
      end
      for (int j = 0; j < NUM_FRAMES; j++) begin
         act[j] = NW'(j) < n_act;
      end
   end

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int j = NUM_FRAMES - 1; j >= 0; j--) begin
         if (act[j] && fvalid_ff[j] && (fpage_ff[j] == page_ff)) begin
            hit     = 1'b1;
            hit_idx = FIDX_W'(j);
         end
      end
   end

   lfu_pr_victim_sel #(
      .NUM_FRAMES  (NUM_FRAMES),
      .COUNT_WIDTH (COUNT_WIDTH),
      .FIDX_W      (FIDX_W)
   ) u_victim_sel (
      .clock       (clock),
      .active      (act),
      .valid       (fvalid_ff),
      .freq        (ffreq_ff),
      .empty_found (empty_found),
      .empty_idx   (empty_idx),
      .min_idx     (min_idx)
   );

   always_comb begin
      if (hit) begin
         sel = hit_idx;
      end else if (empty_found) begin
         sel = empty_idx;
      end else begin
         sel = min_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff <= '0;
      end else if (look && !hit) begin
         fvalid_ff[sel] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (look) begin
         ffreq_ff[sel] <= cnt_new;
         if (!hit) begin
            fpage_ff[sel] <= page_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff <= '0;
      end else if (look && !hit && (fault_ff != FAULT_MAX)) begin
         fault_ff <= fault_ff + FAULT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= look;
      end
   end

   always_ff @(posedge clock) begin
      if (look) begin
         rsp_hit_ff      <= hit;
         rsp_sel_ff      <= sel;
         rsp_ev_valid_ff <= !hit && !empty_found;
         rsp_ev_page_ff  <= (!hit && !empty_found) ? fpage_ff[min_idx] : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_slot    = FRAME_OUT_W'(rsp_sel_ff);
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = PAGE_IN_W'(rsp_ev_page_ff);
   assign rsp_fault_total   = fault_ff;

   a_rsp_after_look: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_LOOK))
      else $error("result strobe without a lookup cycle");

   a_look_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |=> rsp_valid)
      else $error("lookup cycle gave no result");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted_valid)
      else $error("eviction reported on a hit");

   a_fault_mono: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |=> (fault_ff >= $past(fault_ff)))
      else $error("fault total went down");

   a_sel_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> fvalid_ff[rsp_sel_ff])
      else $error("chosen frame left empty");

endmodule

>>> test/tb_lfu_page_replacement_top.sv
module tb_lfu_page_replacement_top import lfu_pr_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_FRAMES    = 16;
   localparam int NUM_PAGES     = 128;
   localparam int COUNT_WIDTH   = 16;
   localparam int STALL_LIMIT   = 2000;
   localparam int SEGMENTS      = 12;
   localparam int SEGMENT_ITEMS = 140;

   localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

   typedef struct packed {
      logic                   hit;
      logic [FRAME_OUT_W-1:0] slot;
      logic                   evicted_valid;
      logic [PAGE_IN_W-1:0]   evicted_page;
      logic [FAULT_W-1:0]     fault_total;
   } lfu_outcome_type;

   typedef enum logic {
      STEP_REF,
      STEP_CFG
   } step_kind_type;

   typedef struct packed {
      step_kind_type        kind;
      logic [PAGE_IN_W-1:0] arg;
      logic                 known;
      lfu_outcome_type      want;
   } step_type;

   localparam step_type DIRECTED [21] = '{
      '{STEP_REF, 7'd0,   1'b1, '{1'b0, 4'd0, 1'b0, 7'd0,   16'd1}},
      '{STEP_REF, 7'd127, 1'b1, '{1'b0, 4'd1, 1'b0, 7'd0,   16'd2}},
      '{STEP_REF, 7'd0,   1'b1, '{1'b1, 4'd0, 1'b0, 7'd0,   16'd2}},
      '{STEP_CFG, 7'd1,   1'b0, '0},
      '{STEP_REF, 7'd127, 1'b1, '{1'b0, 4'd0, 1'b1, 7'd0,   16'd3}},
      '{STEP_CFG, 7'd0,   1'b0, '0},
      '{STEP_REF, 7'd0,   1'b1, '{1'b0, 4'd0, 1'b1, 7'd127, 16'd4}},
      '{STEP_CFG, 7'd31,  1'b0, '0},
      '{STEP_REF, 7'd127, 1'b1, '{1'b1, 4'd1, 1'b0, 7'd0,   16'd4}},
      '{STEP_REF, 7'd5,   1'b1, '{1'b0, 4'd2, 1'b0, 7'd0,   16'd5}},
      '{STEP_CFG, 7'd2,   1'b0, '0},
      '{STEP_REF, 7'd9,   1'b1, '{1'b0, 4'd0, 1'b1, 7'd0,   16'd6}},
      '{STEP_REF, 7'd9,   1'b1, '{1'b1, 4'd0, 1'b0, 7'd0,   16'd6}},
      '{STEP_REF, 7'd64,  1'b1, '{1'b0, 4'd0, 1'b1, 7'd9,   16'd7}},
      '{STEP_CFG, 7'd16,  1'b0, '0},
      '{STEP_REF, 7'd5,   1'b1, '{1'b1, 4'd2, 1'b0, 7'd0,   16'd7}},
      '{STEP_REF, 7'd100, 1'b0, '0},
      '{STEP_REF, 7'd42,  1'b0, '0},
      '{STEP_REF, 7'd127, 1'b0, '0},
      '{STEP_REF, 7'd85,  1'b0, '0},
      '{STEP_REF, 7'd42,  1'b0, '0}
   };

   localparam logic [CSR_W-1:0] FRAME_SETTINGS [SEGMENTS] = '{
      5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd8, 5'd0, 5'd16, 5'd15, 5'd3, 5'd1
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [PAGE_IN_W-1:0]   req_page_number = '0;
   logic                   csr_we = 1'b0;
   logic [CSR_W-1:0]       csr_wdata = '0;
   logic                   rsp_valid;
   logic                   rsp_hit;
   logic [FRAME_OUT_W-1:0] rsp_frame_slot;
   logic                   rsp_evicted_valid;
   logic [PAGE_IN_W-1:0]   rsp_evicted_page;
   logic [FAULT_W-1:0]     rsp_fault_total;

   logic [COUNT_WIDTH-1:0] page_refs [PAGE_IN_N];
   logic [PAGE_IN_W-1:0]   frame_page [NUM_FRAMES];
   logic                   frame_full [NUM_FRAMES];
   logic [COUNT_WIDTH-1:0] frame_freq [NUM_FRAMES];
   logic [FAULT_W-1:0]     faults_seen = '0;
   logic [CSR_W-1:0]       frames_setting = FRAMES_RESET;

   lfu_outcome_type pending_outcomes [$];
   int              mismatches = 0;
   int              stall_cycles = 0;

   always #6 clock = ~clock;

   lfu_page_replacement_top #(
      .NUM_FRAMES  (NUM_FRAMES),
      .NUM_PAGES   (NUM_PAGES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_page_number   (req_page_number),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total)
   );

   function automatic lfu_outcome_type lfu_reference(input logic [PAGE_IN_W-1:0] page);
      lfu_outcome_type        o;
      logic [COUNT_WIDTH-1:0] refs;
      int                     active;
      int                     sel;
      bit                     found;
      o = '0;
      active = (frames_setting == 0) ? 1 :
               ((frames_setting > NUM_FRAMES) ? NUM_FRAMES : int'(frames_setting));
      refs = page_refs[page];
      if (refs != COUNT_TOP) refs = refs + COUNT_WIDTH'(1);
      page_refs[page] = refs;
      for (int j = 0; j < active; j++) begin
         if (!o.hit && frame_full[j] && frame_page[j] == page) begin
            frame_freq[j] = refs;
            o.hit = 1'b1;
            o.slot = FRAME_OUT_W'(j);
         end
      end
      if (!o.hit) begin
         if (faults_seen != FAULT_MAX) faults_seen = faults_seen + FAULT_W'(1);
         found = 1'b0;
         sel = 0;
         for (int j = 0; j < active; j++) begin
            if (!found && !frame_full[j]) begin
               sel = j;
               found = 1'b1;
            end
         end
         if (!found) begin
            for (int j = 1; j < active; j++) begin
               if (frame_freq[j] < frame_freq[sel]) sel = j;
            end
            o.evicted_valid = 1'b1;
            o.evicted_page = frame_page[sel];
         end
         frame_page[sel] = page;
         frame_full[sel] = 1'b1;
         frame_freq[sel] = refs;
         o.slot = FRAME_OUT_W'(sel);
      end
      o.fault_total = faults_seen;
      return o;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] seen,
                                input logic [31:0] wanted);
      $display("%0t ns: %s got %0h, wanted %0h", $time, what, seen, wanted);
      mismatches++;
   endtask

   task automatic send_page(input logic [PAGE_IN_W-1:0] page, input int idle_pct,
                            input logic known, input lfu_outcome_type typed);
      lfu_outcome_type predicted;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_page_number <= page;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = lfu_reference(page);
      pending_outcomes.push_back(known ? typed : predicted);
   endtask

   task automatic write_frames(input logic [CSR_W-1:0] setting);
      start <= 1'b0;
      while (pending_outcomes.size() != 0 || busy !== 1'b0) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= setting;
      @(posedge clock);
      frames_setting = setting;
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      lfu_outcome_type got;
      lfu_outcome_type want;
      if (!reset && rsp_valid === 1'b1) begin
         got = {rsp_hit, rsp_frame_slot, rsp_evicted_valid, rsp_evicted_page,
                rsp_fault_total};
         if (pending_outcomes.size() == 0) begin
            flag_mismatch("result with nothing pending", 32'(got), 0);
         end else begin
            want = pending_outcomes.pop_front();
            if (got.hit !== want.hit)
               flag_mismatch("hit", 32'(got.hit), 32'(want.hit));
            if (got.slot !== want.slot)
               flag_mismatch("frame slot", 32'(got.slot), 32'(want.slot));
            if (got.evicted_valid !== want.evicted_valid)
               flag_mismatch("evicted_valid", 32'(got.evicted_valid),
                             32'(want.evicted_valid));
            if (got.evicted_page !== want.evicted_page)
               flag_mismatch("evicted_page", 32'(got.evicted_page),
                             32'(want.evicted_page));
            if (got.fault_total !== want.fault_total)
               flag_mismatch("fault_total", 32'(got.fault_total),
                             32'(want.fault_total));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[lfu_page_replacement_top] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [CSR_W-1:0]     setting;
      logic [PAGE_IN_W-1:0] base;
      logic [PAGE_IN_W-1:0] page;
      int                   span;
      int                   idle_pct;
      for (int p = 0; p < PAGE_IN_N; p++) page_refs[p] = '0;
      for (int f = 0; f < NUM_FRAMES; f++) begin
         frame_page[f] = '0;
         frame_full[f] = 1'b0;
         frame_freq[f] = '0;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (busy !== 1'b0);

      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].kind == STEP_CFG)
            write_frames(DIRECTED[r].arg[CSR_W-1:0]);
         else
            send_page(DIRECTED[r].arg, 8, DIRECTED[r].known, DIRECTED[r].want);
      end

      // keep most references inside a small working set so hits and evictions both occur
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         setting = (seg == 7) ? CSR_W'($urandom_range(0, 31)) : FRAME_SETTINGS[seg];
         write_frames(setting);
         span = (setting == 0) ? 4 :
                ((setting > NUM_FRAMES) ? NUM_FRAMES + 3 : int'(setting) + 3);
         base = PAGE_IN_W'($urandom_range(0, 127));
         idle_pct = (seg < 4) ? 8 : ((seg < 8) ? 65 : 0);
         for (int i = 0; i < SEGMENT_ITEMS; i++) begin
            if ($urandom_range(99) < 75)
               page = base + PAGE_IN_W'($urandom_range(0, span));
            else
               page = PAGE_IN_W'($urandom_range(0, 127));
            send_page(page, idle_pct, 1'b0, '0);
         end
      end

      write_frames(5'd16);
      for (int i = 0; i < 60; i++) begin
         page = ($urandom_range(99) < 30) ? base : PAGE_IN_W'($urandom_range(0, 127));
         send_page(page, 8, 1'b0, '0);
      end

      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("[lfu_page_replacement_top] OK");
      else
         $display("[lfu_page_replacement_top] ERROR");
      $finish;
   end

endmodule
